// ===== design/ubds_pkg.sv =====
package ubds_pkg;

  // Field and datapath widths
  localparam int BAUD_W = 24;
  localparam int PCLK_W = 32;
  localparam int F_W    = 40;   // pclk * M
  localparam int NUM_W  = 52;   // target and error numerator
  localparam int LIM_W  = 59;   // 100 * target
  localparam int D_W    = 20;   // base * (N + 1)
  localparam int HALF_W = 26;   // half of an error numerator
  localparam int PROD_W = 46;   // HALF_W x D_W partial product
  localparam int CMP_W  = 72;   // NUM_W x D_W full product

  localparam logic [PCLK_W-1:0] PCLK_RESET = 32'd120000000;

  // Fixed rates and band edges
  localparam logic [BAUD_W-1:0] RATE_4M    = 24'd4000000;
  localparam logic [BAUD_W-1:0] RATE_2M    = 24'd2000000;
  localparam logic [BAUD_W-1:0] RATE_1M    = 24'd1000000;
  localparam logic [BAUD_W-1:0] RATE_MIN   = 24'd120;
  localparam logic [BAUD_W-1:0] BAND_LOW   = 24'd7500;

  localparam logic [7:0] N_FIXED_4M = 8'd4;
  localparam logic [7:0] N_FIXED_2M = 8'd9;
  localparam logic [7:0] N_FIXED_1M = 8'd19;
  localparam logic [7:0] N_LAST     = 8'd255;
  localparam logic [6:0] M_LOW_LAST = 7'h7f;

  localparam logic [D_W-1:0] BASE_LOW  = 20'd2048;
  localparam logic [D_W-1:0] BASE_MID  = 20'd32;
  localparam logic [D_W-1:0] BASE_HIGH = 20'd6;

  localparam logic [1:0] PRESCALE_LOW  = 2'd3;
  localparam logic [1:0] PRESCALE_NONE = 2'd0;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Steps of the cross-multiply compare between a row best and the overall best
  typedef enum logic [2:0] {
    CS_A_HI   = 3'd0,
    CS_A_LO   = 3'd1,
    CS_B_HI   = 3'd2,
    CS_B_LO   = 3'd3,
    CS_B_SUM  = 3'd4,
    CS_DECIDE = 3'd5
  } cmp_step_t;

  typedef struct packed {
    logic      latch_in;
    logic      band;
    logic      lim1;
    logic      lim2;
    logic      scan;
    logic      cmp;
    cmp_step_t step;
    logic      finish;
    logic [7:0] n;
    logic [6:0] m_low;
  } ctrl_cmd_t;

  typedef struct packed {
    logic special;
  } dp_sts_t;

endpackage

// ===== design/uart_baud_divider_search.sv =====
// UART baud rate divider search.
// Request channel: drive baud_rate and pulse start while busy is low; the
// transaction is taken at that edge and busy rises on the next cycle.
// Result channel: done is high for exactly one cycle with status,
// modulation_enable, clock_select_bit, prescale_code, divider_n and
// modulation_m valid in that cycle. The receiver cannot stall; the result
// fields hold their values until the next result replaces them.
// Configuration: cfg_we writes cfg_wdata into the peripheral clock register
// (reset value 120 MHz); write only while busy is low.
// Flow: 4, 2 and 1 Mbaud and rates below 120 baud go from the band step
// straight to the result load. Any other rate runs the full search: the
// setup steps (band, limit 1, limit 2), then 256 rows of N, each scanning
// 128 values of M (one candidate per cycle) followed by a compare in which
// a single 26x20 multiplier cross-checks the row winner against the best
// so far, then the result load. One request at a time; the next is taken
// at the earliest in the done cycle. Most of the search time goes to the
// candidate scan, less to the per-row compare.
// Reset (synchronous, active high) returns to idle with busy and done low.
module uart_baud_divider_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] baud_rate,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        done,
  output logic        status,
  output logic        modulation_enable,
  output logic        clock_select_bit,
  output logic [1:0]  prescale_code,
  output logic [7:0]  divider_n,
  output logic [7:0]  modulation_m
);

  // Command and status between sequencer and datapath
  ubds_pkg::ctrl_cmd_t cmd;
  ubds_pkg::dp_sts_t   sts;

  // Sequencer: walks setup, row scan, per-row compare and result load
  ubds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: error evaluation, row and overall best, result registers
  ubds_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .baud_rate         (baud_rate),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .status            (status),
    .modulation_enable (modulation_enable),
    .clock_select_bit  (clock_select_bit),
    .prescale_code     (prescale_code),
    .divider_n         (divider_n),
    .modulation_m      (modulation_m)
  );

endmodule

// ===== design/ubds_datapath.sv =====
module ubds_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  ubds_pkg::ctrl_cmd_t           cmd,
  output ubds_pkg::dp_sts_t             sts,
  input  logic [ubds_pkg::BAUD_W-1:0]   baud_rate,
  input  logic                          cfg_we,
  input  logic [ubds_pkg::PCLK_W-1:0]   cfg_wdata,
  output logic                          status,
  output logic                          modulation_enable,
  output logic                          clock_select_bit,
  output logic [1:0]                    prescale_code,
  output logic [7:0]                    divider_n,
  output logic [7:0]                    modulation_m
);

  logic [ubds_pkg::PCLK_W-1:0] pclk;
  logic [ubds_pkg::BAUD_W-1:0] baud;

  logic [ubds_pkg::D_W-1:0]   base;
  logic                       cs;
  logic [1:0]                 pc;
  logic [ubds_pkg::NUM_W-1:0] step_t;
  logic [ubds_pkg::LIM_W-1:0] lim_tmp;
  logic [ubds_pkg::LIM_W-1:0] lim_step;

  logic [ubds_pkg::NUM_W-1:0] target;
  logic [ubds_pkg::LIM_W-1:0] lim;
  logic [ubds_pkg::D_W-1:0]   d;
  logic [ubds_pkg::F_W-1:0]   f;

  logic                       row_found;
  logic [ubds_pkg::NUM_W-1:0] row_num;
  logic [7:0]                 row_m;

  logic                       best_found;
  logic [ubds_pkg::NUM_W-1:0] best_num;
  logic [ubds_pkg::D_W-1:0]   best_d;
  logic [7:0]                 best_n;
  logic [7:0]                 best_m;

  logic [ubds_pkg::PROD_W-1:0] prod;
  logic [ubds_pkg::CMP_W-1:0]  lhs;
  logic [ubds_pkg::CMP_W-1:0]  rhs;

  logic is_4m, is_2m, is_1m, is_low;

  assign is_4m = (baud == ubds_pkg::RATE_4M);
  assign is_2m = (baud == ubds_pkg::RATE_2M);
  assign is_1m = (baud == ubds_pkg::RATE_1M);
  assign is_low = (baud < ubds_pkg::RATE_MIN);
  assign sts.special = is_4m || is_2m || is_1m || is_low;

  // Candidate error for the current (N, M)
  logic [ubds_pkg::NUM_W-1:0] f_ext;
  logic [ubds_pkg::NUM_W:0]   diff_ft;
  logic [ubds_pkg::NUM_W-1:0] num;
  logic                       in_bound;
  logic                       row_better;

  assign f_ext = {{(ubds_pkg::NUM_W-ubds_pkg::F_W){1'b0}}, f};
  assign diff_ft = {1'b0, f_ext} - {1'b0, target};
  assign num = diff_ft[ubds_pkg::NUM_W] ? (target - f_ext) : diff_ft[ubds_pkg::NUM_W-1:0];
  assign in_bound = {{(ubds_pkg::LIM_W-ubds_pkg::NUM_W){1'b0}}, num} < lim;
  assign row_better = !row_found || (num < row_num);

  // Shared multiplier operands
  logic [ubds_pkg::HALF_W-1:0] mul_a;
  logic [ubds_pkg::D_W-1:0]    mul_b;

  always_comb begin
    case (cmd.step)
      ubds_pkg::CS_A_HI: begin
        mul_a = row_num[ubds_pkg::NUM_W-1:ubds_pkg::HALF_W];
        mul_b = best_d;
      end
      ubds_pkg::CS_A_LO: begin
        mul_a = row_num[ubds_pkg::HALF_W-1:0];
        mul_b = best_d;
      end
      ubds_pkg::CS_B_HI: begin
        mul_a = best_num[ubds_pkg::NUM_W-1:ubds_pkg::HALF_W];
        mul_b = d;
      end
      default: begin
        mul_a = best_num[ubds_pkg::HALF_W-1:0];
        mul_b = d;
      end
    endcase
  end

  logic [ubds_pkg::LIM_W-1:0] lim_sum;
  logic [ubds_pkg::NUM_W-1:0] step_next;
  logic                       take_row;

  assign lim_sum = lim_tmp + ubds_pkg::LIM_W'({step_t, 2'b00});
  assign take_row = row_found && (!best_found || (lhs < rhs));

  always_comb begin
    if (baud < ubds_pkg::BAND_LOW) begin
      step_next = ubds_pkg::NUM_W'({baud, 19'b0});
    end else if (baud > ubds_pkg::RATE_1M) begin
      step_next = ubds_pkg::NUM_W'({baud, 10'b0}) + ubds_pkg::NUM_W'({baud, 9'b0});
    end else begin
      step_next = ubds_pkg::NUM_W'({baud, 13'b0});
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pclk <= ubds_pkg::PCLK_RESET;
    end else if (cfg_we) begin
      pclk <= cfg_wdata;
    end
  end

  // Search flags
  always_ff @(posedge clk) begin
    if (rst) begin
      row_found  <= 1'b0;
      best_found <= 1'b0;
    end else if (cmd.lim2) begin
      row_found  <= 1'b0;
      best_found <= 1'b0;
    end else if (cmd.scan) begin
      if (in_bound && row_better) begin
        row_found <= 1'b1;
      end
    end else if (cmd.cmp && cmd.step == ubds_pkg::CS_DECIDE) begin
      if (take_row) begin
        best_found <= 1'b1;
      end
      row_found <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      baud <= baud_rate;
    end

    if (cmd.band) begin
      step_t <= step_next;
      if (baud < ubds_pkg::BAND_LOW) begin
        base <= ubds_pkg::BASE_LOW;
        cs   <= 1'b0;
        pc   <= ubds_pkg::PRESCALE_LOW;
      end else if (baud > ubds_pkg::RATE_1M) begin
        base <= ubds_pkg::BASE_HIGH;
        cs   <= 1'b1;
        pc   <= ubds_pkg::PRESCALE_NONE;
      end else begin
        base <= ubds_pkg::BASE_MID;
        cs   <= 1'b0;
        pc   <= ubds_pkg::PRESCALE_NONE;
      end
    end

    if (cmd.lim1) begin
      lim_tmp <= ubds_pkg::LIM_W'({step_t, 6'b0}) + ubds_pkg::LIM_W'({step_t, 5'b0});
    end

    if (cmd.lim2) begin
      lim_step <= lim_sum;
      lim      <= lim_sum;
      target   <= step_t;
      d        <= base;
      f        <= ubds_pkg::F_W'({pclk, 7'b0});
      best_num <= '0;
      best_d   <= '0;
    end

    if (cmd.scan) begin
      f <= f + ubds_pkg::F_W'(pclk);
      if (in_bound && row_better) begin
        row_num <= num;
        row_m   <= {1'b1, cmd.m_low};
      end
    end

    if (cmd.cmp) begin
      prod <= ubds_pkg::PROD_W'(mul_a) * ubds_pkg::PROD_W'(mul_b);
      case (cmd.step)
        ubds_pkg::CS_A_LO:  lhs <= {prod, {ubds_pkg::HALF_W{1'b0}}};
        ubds_pkg::CS_B_HI:  lhs <= lhs + ubds_pkg::CMP_W'(prod);
        ubds_pkg::CS_B_LO:  rhs <= {prod, {ubds_pkg::HALF_W{1'b0}}};
        ubds_pkg::CS_B_SUM: rhs <= rhs + ubds_pkg::CMP_W'(prod);
        ubds_pkg::CS_DECIDE: begin
          if (take_row) begin
            best_num <= row_num;
            best_d   <= d;
            best_n   <= cmd.n;
            best_m   <= row_m;
          end
          target <= target + step_t;
          lim    <= lim + lim_step;
          d      <= d + base;
          f      <= ubds_pkg::F_W'({pclk, 7'b0});
        end
        default: begin
        end
      endcase
    end

    if (cmd.finish) begin
      if (is_4m || is_2m || is_1m) begin
        status            <= ubds_pkg::STATUS_OK;
        modulation_enable <= 1'b0;
        clock_select_bit  <= 1'b1;
        prescale_code     <= ubds_pkg::PRESCALE_NONE;
        modulation_m      <= 8'd0;
        divider_n         <= is_4m ? ubds_pkg::N_FIXED_4M :
                             (is_2m ? ubds_pkg::N_FIXED_2M : ubds_pkg::N_FIXED_1M);
      end else if (is_low || !best_found || best_n == ubds_pkg::N_LAST) begin
        status            <= ubds_pkg::STATUS_ERR;
        modulation_enable <= 1'b0;
        clock_select_bit  <= 1'b0;
        prescale_code     <= ubds_pkg::PRESCALE_NONE;
        divider_n         <= 8'd0;
        modulation_m      <= 8'd0;
      end else begin
        status            <= ubds_pkg::STATUS_OK;
        modulation_enable <= 1'b1;
        clock_select_bit  <= cs;
        prescale_code     <= pc;
        divider_n         <= best_n;
        modulation_m      <= best_m;
      end
    end
  end

endmodule

// ===== design/ubds_ctrl.sv =====
module ubds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ubds_pkg::dp_sts_t   sts,
  output ubds_pkg::ctrl_cmd_t cmd,
  output logic                busy,
  output logic                done
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_BAND   = 7'b0000010,
    ST_LIM1   = 7'b0000100,
    ST_LIM2   = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_CMP    = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t              state;
  logic [7:0]          ncnt;
  logic [6:0]          mcnt;
  ubds_pkg::cmp_step_t step;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd.latch_in = (state == ST_IDLE) && start;
    cmd.band     = (state == ST_BAND);
    cmd.lim1     = (state == ST_LIM1);
    cmd.lim2     = (state == ST_LIM2);
    cmd.scan     = (state == ST_SCAN);
    cmd.cmp      = (state == ST_CMP);
    cmd.step     = step;
    cmd.finish   = (state == ST_FINISH);
    cmd.n        = ncnt;
    cmd.m_low    = mcnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ncnt  <= '0;
      mcnt  <= '0;
      step  <= ubds_pkg::CS_A_HI;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          ncnt <= '0;
          mcnt <= '0;
          if (start) begin
            state <= ST_BAND;
          end
        end
        ST_BAND: state <= sts.special ? ST_FINISH : ST_LIM1;
        ST_LIM1: state <= ST_LIM2;
        ST_LIM2: state <= ST_SCAN;
        ST_SCAN: begin
          mcnt <= mcnt + 7'd1;
          if (mcnt == ubds_pkg::M_LOW_LAST) begin
            state <= ST_CMP;
            step  <= ubds_pkg::CS_A_HI;
          end
        end
        ST_CMP: begin
          case (step)
            ubds_pkg::CS_A_HI:  step <= ubds_pkg::CS_A_LO;
            ubds_pkg::CS_A_LO:  step <= ubds_pkg::CS_B_HI;
            ubds_pkg::CS_B_HI:  step <= ubds_pkg::CS_B_LO;
            ubds_pkg::CS_B_LO:  step <= ubds_pkg::CS_B_SUM;
            ubds_pkg::CS_B_SUM: step <= ubds_pkg::CS_DECIDE;
            default: begin
              step <= ubds_pkg::CS_A_HI;
              if (ncnt == ubds_pkg::N_LAST) begin
                state <= ST_FINISH;
              end else begin
                ncnt  <= ncnt + 8'd1;
                state <= ST_SCAN;
              end
            end
          endcase
        end
        ST_FINISH: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("result strobe without a finish step");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> (state == ST_BAND))
    else $error("accepted transaction did not start the search");

  a_row_end_compare: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && mcnt == ubds_pkg::M_LOW_LAST) |=>
      (state == ST_CMP && step == ubds_pkg::CS_A_HI))
    else $error("row scan did not hand over to the compare sequence");

endmodule
